// ===== rtl/ile_pkg.sv =====
// Shared types and constants for the indexed list engine.
// No dependencies; used by the engine, its bound checks and the verification files.

package ile_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT     = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_DUMP       = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_DRAIN,
        S_PUT,
        S_REPORT
    } state_t;

    // what the entry walk is doing
    typedef enum logic [1:0] {
        K_INS,
        K_REM,
        K_DUMP
    } kind_t;

    // outcome of decoding one accepted transaction
    typedef struct packed {
        logic go_move;
        logic go_put;
    } route_t;

endpackage

// ===== rtl/ile_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/indexed_list_engine.sv =====
// Indexed list engine: bounded ordered list of signed 32-bit values in one RAM.
// Depends on ile_pkg and ile_ram.
//
// Usage
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low; op, value and position are sampled then. busy stays high
//   until every result of that transaction has been shown.
//   Result channel: each result sits on status/element/size/last for one
//   cycle with strobe high; last marks the final result of a transaction.
//   There is no back-pressure, so results are never held.
// Sequencing
//   Insert with entries to shift: move them up, drain, write, report; append:
//   write, report; full list: report. Remove with entries to shift: move them
//   down, drain, report; otherwise report. Dump: elements from the first in
//   order, one per cycle, the final one during the drain. Other codes: report.
//   The RAM moves one entry per cycle (read one, write the neighbour in the
//   next cycle), which sets the cost of positional inserts, removes and dumps.
// Reset clears the element count and the sequencer; RAM contents are not
//   cleared, since only entries below the count are ever read.

module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
    localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ile_pkg::OP_W-1:0]          op,
    input  logic signed [ile_pkg::DATA_W-1:0] value,
    input  logic [ile_pkg::POS_W-1:0]         position,
    output logic                              strobe,
    output logic [ile_pkg::ST_W-1:0]          status,
    output logic signed [ile_pkg::DATA_W-1:0] element,
    output logic [CW-1:0]                     size,
    output logic                              last
);

    localparam int XW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

    ile_pkg::state_t  state_reg, state_next;
    ile_pkg::kind_t   kind_reg, kind_next;
    ile_pkg::status_t st_reg, st_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic [AW-1:0]    end_reg, end_next;
    logic [AW-1:0]    tgt_reg, tgt_next;
    logic [AW-1:0]    pwa_reg, pwa_next;
    logic [ile_pkg::DATA_W-1:0] val_reg, val_next;
    logic             pend_reg, pend_next;

    ile_pkg::op_t     op_code;
    ile_pkg::route_t  route;
    logic             accept;
    logic             full;
    logic             empty;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    ins_p_x;
    logic [XW-1:0]    rm_p_x;
    logic [AW-1:0]    last_a;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ile_pkg::DATA_W-1:0] ram_wdata;
    logic [ile_pkg::DATA_W-1:0] ram_rdata;

    assign op_code = ile_pkg::op_t'(op);
    assign accept  = start && (state_reg == ile_pkg::S_IDLE);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign cnt_x   = XW'(count_reg);
    assign pos_x   = XW'(position);
    assign last_a  = AW'(count_reg - CW'(1));

    always_comb
    begin
        ins_p_x = '0;
        rm_p_x  = '0;
        if (op_code == ile_pkg::OP_PUSH_BACK)
        begin
            ins_p_x = cnt_x;
        end
        else if (op_code == ile_pkg::OP_INSERT)
        begin
            ins_p_x = (pos_x > cnt_x) ? cnt_x : pos_x;
        end
        if (op_code == ile_pkg::OP_POP_BACK)
        begin
            rm_p_x = cnt_x - XW'(1);
        end
        else if (op_code == ile_pkg::OP_REMOVE)
        begin
            rm_p_x = pos_x;
        end
    end

    // transaction decode and datapath register updates
    always_comb
    begin
        route      = '0;
        kind_next  = kind_reg;
        st_next    = st_reg;
        count_next = count_reg;
        rp_next    = rp_reg;
        end_next   = end_reg;
        tgt_next   = tgt_reg;
        val_next   = val_reg;
        pend_next  = (state_reg == ile_pkg::S_MOVE);
        pwa_next   = (kind_reg == ile_pkg::K_INS) ? AW'(rp_reg + AW'(1))
                                                  : AW'(rp_reg - AW'(1));
        if (accept)
        begin
            unique case (op_code) inside
                ile_pkg::OP_PUSH_FRONT, ile_pkg::OP_PUSH_BACK, ile_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        st_next = ile_pkg::ST_FULL;
                    end
                    else
                    begin
                        st_next    = ile_pkg::ST_OK;
                        kind_next  = ile_pkg::K_INS;
                        count_next = CW'(count_reg + CW'(1));
                        val_next   = value;
                        tgt_next   = AW'(ins_p_x);
                        end_next   = AW'(ins_p_x);
                        rp_next    = last_a;
                        if (ins_p_x == cnt_x)
                        begin
                            route.go_put = 1'b1;
                        end
                        else
                        begin
                            route.go_move = 1'b1;
                        end
                    end
                end
                ile_pkg::OP_POP_FRONT, ile_pkg::OP_POP_BACK, ile_pkg::OP_REMOVE:
                begin
                    if (empty || (rm_p_x >= cnt_x))
                    begin
                        st_next = ile_pkg::ST_NONE;
                    end
                    else
                    begin
                        st_next    = ile_pkg::ST_OK;
                        kind_next  = ile_pkg::K_REM;
                        count_next = CW'(count_reg - CW'(1));
                        rp_next    = AW'(rm_p_x + XW'(1));
                        end_next   = last_a;
                        route.go_move = (rm_p_x != (cnt_x - XW'(1)));
                    end
                end
                ile_pkg::OP_DUMP:
                begin
                    if (empty)
                    begin
                        st_next = ile_pkg::ST_NONE;
                    end
                    else
                    begin
                        st_next       = ile_pkg::ST_OK;
                        kind_next     = ile_pkg::K_DUMP;
                        rp_next       = '0;
                        end_next      = last_a;
                        route.go_move = 1'b1;
                    end
                end
                default:
                begin
                    st_next = ile_pkg::ST_OK;
                end
            endcase
        end
        else if ((state_reg == ile_pkg::S_MOVE) && (rp_reg != end_reg))
        begin
            rp_next = (kind_reg == ile_pkg::K_INS) ? AW'(rp_reg - AW'(1))
                                                   : AW'(rp_reg + AW'(1));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ile_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (route.go_move)
                    begin
                        state_next = ile_pkg::S_MOVE;
                    end
                    else if (route.go_put)
                    begin
                        state_next = ile_pkg::S_PUT;
                    end
                    else
                    begin
                        state_next = ile_pkg::S_REPORT;
                    end
                end
            end
            ile_pkg::S_MOVE:
            begin
                if (rp_reg == end_reg)
                begin
                    state_next = ile_pkg::S_DRAIN;
                end
            end
            ile_pkg::S_DRAIN:
            begin
                unique case (kind_reg)
                    ile_pkg::K_INS:  state_next = ile_pkg::S_PUT;
                    ile_pkg::K_REM:  state_next = ile_pkg::S_REPORT;
                    default:         state_next = ile_pkg::S_IDLE;
                endcase
            end
            ile_pkg::S_PUT:
            begin
                state_next = ile_pkg::S_REPORT;
            end
            ile_pkg::S_REPORT:
            begin
                state_next = ile_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and RAM controls
    always_comb
    begin
        busy      = (state_reg != ile_pkg::S_IDLE);
        strobe    = (state_reg == ile_pkg::S_REPORT)
                 || (pend_reg && (kind_reg == ile_pkg::K_DUMP));
        last      = (state_reg == ile_pkg::S_REPORT)
                 || ((state_reg == ile_pkg::S_DRAIN) && (kind_reg == ile_pkg::K_DUMP));
        element   = (pend_reg && (kind_reg == ile_pkg::K_DUMP)) ? ram_rdata : '0;
        status    = st_reg;
        size      = count_reg;
        ram_we    = (state_reg == ile_pkg::S_PUT)
                 || (pend_reg && (kind_reg != ile_pkg::K_DUMP));
        ram_waddr = (state_reg == ile_pkg::S_PUT) ? tgt_reg : pwa_reg;
        ram_wdata = (state_reg == ile_pkg::S_PUT) ? val_reg : ram_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ile_pkg::S_IDLE;
            kind_reg  <= ile_pkg::K_INS;
            st_reg    <= ile_pkg::ST_OK;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            st_reg    <= st_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg  <= rp_next;
        end_reg <= end_next;
        tgt_reg <= tgt_next;
        pwa_reg <= pwa_next;
        val_reg <= val_next;
    end

    ile_ram #(
        .WIDTH (ile_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/ile_checker.sv =====
// Port-level checks for indexed_list_engine, attached by bind.
// Depends on ile_pkg.

module ile_props #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              strobe,
    input logic [ile_pkg::ST_W-1:0]          status,
    input logic signed [ile_pkg::DATA_W-1:0] element,
    input logic [CW-1:0]                     size,
    input logic                              last
);

    // results only appear while a transaction is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result straight after final result");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != ile_pkg::ST_OK)) |-> (last && (element == '0)))
        else $error("error result not single or element non-zero");

    a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == ile_pkg::ST_FULL)) |-> (size == CW'(CAPACITY)))
        else $error("full status with list not at capacity");

endmodule

bind indexed_list_engine ile_props #(
    .CAPACITY (CAPACITY)
) u_ile_props (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .strobe  (strobe),
    .status  (status),
    .element (element),
    .size    (size),
    .last    (last)
);

// ===== verif/ile_checker.sv =====
// Result checker for the indexed list engine: keeps a queue model of the list,
// predicts the results of each command and compares them with the result channel.
// Depends on ile_pkg only.

module ile_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [ile_pkg::OP_W-1:0]          op,
    input  logic signed [ile_pkg::DATA_W-1:0] value,
    input  logic [ile_pkg::POS_W-1:0]         position,
    input  logic                              strobe,
    input  logic [ile_pkg::ST_W-1:0]          status,
    input  logic signed [ile_pkg::DATA_W-1:0] element,
    input  logic [ile_pkg::POS_W-1:0]         size,
    input  logic                              last,
    output int                                errors,
    output int                                outstanding,
    output int                                list_len,
    output int                                peak_len,
    output int                                results_seen,
    output int                                full_refusals,
    output int                                missing_removes
);
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] element;
        logic [POS_W-1:0]         size;
        logic                     last;
    } list_result_t;

    logic signed [DATA_W-1:0] list_q[$];
    list_result_t             expected_q[$];

    initial
    begin
        errors          = 0;
        outstanding     = 0;
        list_len        = 0;
        peak_len        = 0;
        results_seen    = 0;
        full_refusals   = 0;
        missing_removes = 0;
    end

    function automatic void queue_result(status_t st, logic signed [DATA_W-1:0] elem,
                                         logic fin);
        list_result_t r;
        r.status  = st;
        r.element = elem;
        r.size    = POS_W'(list_q.size());
        r.last    = fin;
        expected_q.push_back(r);
    endfunction

    // applies one command to the list model and queues the results it should give
    function automatic void apply_command(logic [OP_W-1:0] code,
                                          logic signed [DATA_W-1:0] v,
                                          logic [POS_W-1:0] pos);
        status_t st;
        int      n;
        int      p;
        int      i;
        st = ST_OK;
        n  = list_q.size();
        p  = 0;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
            begin
                if (n >= CAP)
                begin
                    st = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    if (code == OP_PUSH_BACK)
                        p = n;
                    else if (code == OP_INSERT)
                        p = (int'(pos) > n) ? n : int'(pos);
                    list_q.insert(p, v);
                end
                queue_result(st, '0, 1'b1);
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE:
            begin
                if (code == OP_POP_BACK)
                    p = n - 1;
                else if (code == OP_REMOVE)
                    p = int'(pos);
                if (n == 0 || p >= n)
                begin
                    st = ST_NONE;
                    missing_removes++;
                end
                else
                    list_q.delete(p);
                queue_result(st, '0, 1'b1);
            end
            OP_DUMP:
            begin
                if (n == 0)
                    queue_result(ST_NONE, '0, 1'b1);
                else
                    for (i = 0; i < n; i++)
                        queue_result(ST_OK, list_q[i], (i == n - 1));
            end
            default:
                queue_result(ST_OK, '0, 1'b1);   // spare code: no change
        endcase
        if (list_q.size() > peak_len)
            peak_len = list_q.size();
    endfunction

    always @(posedge clk)
    begin
        list_result_t exp;
        if (rst_n)
        begin
            if (strobe)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $error("result with nothing expected: status %0d element %0d size %0d",
                           status, element, size);
                end
                else
                begin
                    exp = expected_q.pop_front();
                    if (status !== exp.status)
                    begin
                        errors++;
                        $error("status: expected %0d, got %0d", exp.status, status);
                    end
                    if (element !== exp.element)
                    begin
                        errors++;
                        $error("element: expected %0d, got %0d", exp.element, element);
                    end
                    if (size !== exp.size)
                    begin
                        errors++;
                        $error("size: expected %0d, got %0d", exp.size, size);
                    end
                    if (last !== exp.last)
                    begin
                        errors++;
                        $error("last: expected %0d, got %0d", exp.last, last);
                    end
                end
            end
            // results always lag the command, so checking first keeps order safe
            if (start && !busy)
                apply_command(op, value, position);
            outstanding = expected_q.size();
            list_len    = list_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the indexed list engine: clock, reset, command stimulus and verdict.
// Depends on ile_pkg, the engine RTL and ile_checker.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int                       RANDOM_CMDS = 350;
    localparam int unsigned              CYCLE_LIMIT = 400000;
    localparam int                       DRAIN_WAIT  = CAPACITY_DEF + 8;
    localparam logic [OP_W-1:0]          OP_SPARE    = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MAX     = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN     = 32'sh80000000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [OP_W-1:0]            op;
    logic signed [DATA_W-1:0]   value;
    logic [POS_W-1:0]           position;
    logic                       strobe;
    logic [ST_W-1:0]            status;
    logic signed [DATA_W-1:0]   element;
    logic [POS_W-1:0]           size;
    logic                       last;

    int          errors;
    int          outstanding;
    int          list_len;
    int          peak_len;
    int          results_seen;
    int          full_refusals;
    int          missing_removes;
    int          sent;
    int unsigned cycles;
    bit          no_gaps;

    indexed_list_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .value    (value),
        .position (position),
        .strobe   (strobe),
        .status   (status),
        .element  (element),
        .size     (size),
        .last     (last)
    );

    ile_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .value           (value),
        .position        (position),
        .strobe          (strobe),
        .status          (status),
        .element         (element),
        .size            (size),
        .last            (last),
        .errors          (errors),
        .outstanding     (outstanding),
        .list_len        (list_len),
        .peak_len        (peak_len),
        .results_seen    (results_seen),
        .full_refusals   (full_refusals),
        .missing_removes (missing_removes)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return -1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // mostly positions from zero up to the current length, sometimes anything the port can carry
    function automatic logic [POS_W-1:0] pick_position(int span);
        if ($urandom_range(99) < 20 || span <= 0)
            return POS_W'($urandom_range(127));
        return POS_W'($urandom_range(span));
    endfunction

    // one command transaction: held until the engine takes it; start stays high
    task automatic issue(logic [OP_W-1:0] code, logic signed [DATA_W-1:0] v,
                         logic [POS_W-1:0] pos);
        start    = 1'b1;
        op       = code;
        value    = v;
        position = pos;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        sent++;
    endtask

    task automatic idle_cycles(int n);
        start = 1'b0;
        repeat (n)
        begin
            op       = OP_W'($urandom);
            value    = $urandom;
            position = POS_W'($urandom);
            @(negedge clk);
        end
    endtask

    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(99) < 15)
            idle_cycles($urandom_range(1, 4));
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // segments: grow, mixed, shrink, grow, shrink
    function automatic logic [OP_W-1:0] pick_op(int idx);
        int seg;
        int r;
        seg = idx / 70;
        r   = $urandom_range(99);
        if (seg == 0 || seg == 3)
            return (r < 92) ? OP_W'($urandom_range(OP_INSERT))
                            : OP_W'($urandom_range(OP_POP_FRONT, OP_SPARE));
        if (seg == 2 || seg == 4)
            return (r < 80) ? OP_W'($urandom_range(OP_POP_FRONT, OP_REMOVE))
                            : OP_W'($urandom_range(OP_SPARE));
        return OP_W'($urandom_range(OP_SPARE));
    endfunction

    initial
    begin
        logic [OP_W-1:0] code;
        int              i;
        rst_n    = 1'b0;
        start    = 1'b0;
        op       = '0;
        value    = '0;
        position = '0;
        sent     = 0;
        no_gaps  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        idle_cycles(2);

        // directed: empty list corners first, then ends and middles
        issue(OP_DUMP, '0, '0);
        issue(OP_POP_FRONT, '0, '0);
        issue(OP_POP_BACK, '0, '0);
        issue(OP_REMOVE, '0, '0);
        issue(OP_REMOVE, VAL_MAX, 7'd127);
        issue(OP_SPARE, VAL_MIN, 7'd127);
        issue(OP_PUSH_FRONT, VAL_MAX, '0);
        maybe_gap();
        issue(OP_PUSH_BACK, VAL_MIN, 7'd127);
        issue(OP_INSERT, -1, 7'd127);
        issue(OP_INSERT, '0, '0);
        issue(OP_INSERT, 32'sh5a5a5a5a, 7'd2);
        issue(OP_DUMP, '0, '0);
        issue(OP_REMOVE, '0, 7'd4);
        maybe_gap();
        issue(OP_REMOVE, '0, 7'd2);
        issue(OP_REMOVE, '0, 7'd64);
        issue(OP_SPARE, '0, '0);
        issue(OP_POP_FRONT, '0, '0);
        issue(OP_POP_BACK, '0, '0);
        issue(OP_DUMP, '0, '0);
        issue(OP_INSERT, 32'sh12345678, 7'd64);
        issue(OP_POP_FRONT, '0, '0);
        issue(OP_POP_BACK, '0, '0);
        issue(OP_POP_BACK, '0, '0);
        wait_drained();

        for (i = 0; i < RANDOM_CMDS; i++)
        begin
            no_gaps = (i >= 100 && i < 180);
            if (i == 175)
                wait_drained();
            code = pick_op(i);
            if (code == OP_REMOVE)
                issue(code, pick_value(), pick_position(list_len - 1));
            else
                issue(code, pick_value(), pick_position(list_len));
            maybe_gap();
        end

        wait_drained();
        idle_cycles(DRAIN_WAIT);
        $display("%0d commands sent, %0d results checked, list peaked at %0d of %0d entries",
                 sent, results_seen, peak_len, CAPACITY_DEF);
        $display("%0d inserts refused on a full list, %0d removes with no element",
                 full_refusals, missing_removes);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
